// File: src/vlqe_pkg.sv
// vlqe_pkg: shared types and constants for the varint integer encoder
// used by vlqe_front, vlqe_queue, vlqe_back and the top level
`default_nettype none

package vlqe_pkg;

  // longest encoding: ten 7-bit groups for a 64-bit value
  localparam int unsigned MAX_BYTES   = 10;
  localparam int unsigned BYTES_W     = MAX_BYTES * 8;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [1:0] REG_FORMAT   = 2'd0;
  localparam logic [1:0] REG_SIGNED   = 2'd1;
  localparam logic [1:0] REG_WIDE     = 2'd2;
  localparam logic [1:0] REG_CAPACITY = 2'd3;

  // one classified value, bytes left-aligned with the first byte on top
  typedef struct packed {
    logic [BYTES_W-1:0] bytes;
    logic [LEN_W-1:0]   len;
    logic               grp7;
    logic               err;
  } entry_t;

endpackage

`default_nettype wire

// File: src/varint_integer_encoder.sv
// varint_integer_encoder: top level, front classifier, entry queue and byte emitter
// depends on vlqe_pkg, vlqe_front, vlqe_queue, vlqe_back
// throughput: one output byte per cycle while pop keeps the output free; a value gives
// 1 to 10 bytes, set by its encoded length (an error result gives a single byte)
// reset: synchronous, clears queue and output, registers return to defaults
`default_nettype none

module varint_integer_encoder #(
  parameter int unsigned QueueDepth = vlqe_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [63:0] value,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             last,
  output logic             status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);

  logic             q_push;
  logic             q_pop;
  logic             q_empty;
  vlqe_pkg::entry_t q_entry;
  vlqe_pkg::entry_t q_head;

  vlqe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .q_full    (full),
    .value     (value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  vlqe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wr_entry (q_entry),
    .rd       (q_pop),
    .head     (q_head),
    .full     (full),
    .q_empty  (q_empty)
  );

  vlqe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .last     (last),
    .status   (status)
  );

endmodule

`default_nettype wire

// File: src/vlqe_front.sv
// vlqe_front: configuration registers and classification of each value
// into digits, leading-group trim, length and error; depends on vlqe_pkg
`default_nettype none

module vlqe_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire logic                q_full,
  input  wire logic [63:0]         value,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [3:0]          cfg_data,
  output logic                     q_push,
  output vlqe_pkg::entry_t         q_entry
);

  logic       format_select;
  logic       signed_values;
  logic       wide_values;
  logic [3:0] output_capacity;

  logic                           grp7;
  logic                           neg;
  logic [63:0]                    v;
  logic [3:0]                     n;
  logic [7:0]                     fill;
  logic [7:0]                     d [vlqe_pkg::MAX_BYTES];
  logic [vlqe_pkg::MAX_BYTES-1:0] hb;
  logic [vlqe_pkg::MAX_BYTES-1:0] skip;
  logic [3:0]                     off;
  logic [3:0]                     len;
  logic                           err;
  logic [vlqe_pkg::BYTES_W-1:0]   dv;

  assign cfg_ready = 1'b1;
  assign q_push    = push && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_select   <= 1'b0;
      signed_values   <= 1'b0;
      wide_values     <= 1'b1;
      output_capacity <= 4'd10;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vlqe_pkg::REG_FORMAT:   format_select   <= cfg_data[0];
        vlqe_pkg::REG_SIGNED:   signed_values   <= cfg_data[0];
        vlqe_pkg::REG_WIDE:     wide_values     <= cfg_data[0];
        vlqe_pkg::REG_CAPACITY: output_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    int sh;
    sh   = 0;
    grp7 = !format_select;
    v    = wide_values ? value : {32'b0, value[31:0]};
    neg  = signed_values && (wide_values ? v[63] : v[31]);
    if (grp7) n = wide_values ? 4'd10 : 4'd5;
    else      n = wide_values ? 4'd8 : 4'd4;

    for (int i = 0; i < vlqe_pkg::MAX_BYTES; i++) d[i] = 8'h00;
    if (grp7 && wide_values) begin
      for (int i = 0; i < 10; i++) begin
        sh = 7 * (9 - i);
        if (sh > 63) sh = 63;
        d[i] = {1'b0, 7'(v >> sh)};
      end
    end else if (grp7) begin
      for (int i = 0; i < 5; i++) d[i] = {1'b0, 7'(v >> (7 * (4 - i)))};
    end else if (wide_values) begin
      for (int i = 0; i < 8; i++) d[i] = 8'(v >> (8 * (7 - i)));
    end else begin
      for (int i = 0; i < 4; i++) d[i] = 8'(v >> (8 * (3 - i)));
    end
    // sign extension of the top group
    if (neg && grp7) d[0] = d[0] | (wide_values ? 8'h7F : 8'h70);

    fill = neg ? (grp7 ? 8'h7F : 8'hFF) : 8'h00;
    for (int i = 0; i < vlqe_pkg::MAX_BYTES; i++) hb[i] = grp7 ? d[i][6] : d[i][7];

    // a leading digit may go while it only repeats the sign
    skip = '0;
    for (int i = 0; i < vlqe_pkg::MAX_BYTES - 1; i++) begin
      if (4'(i + 1) < n) begin
        if (signed_values) skip[i] = (d[i] == fill) && (hb[i+1] == neg);
        else               skip[i] = (d[i] == 8'h00);
      end
    end

    // first digit kept: lowest index that is not skipped
    off = 4'd0;
    for (int i = vlqe_pkg::MAX_BYTES - 1; i >= 0; i--) begin
      if (!skip[i]) off = 4'(i);
    end
    len = n - off;
    err = len > output_capacity;

    for (int i = 0; i < vlqe_pkg::MAX_BYTES; i++) begin
      dv[8*(vlqe_pkg::MAX_BYTES-1-i) +: 8] = d[i];
    end

    q_entry.bytes = err ? '0 : (dv << {off, 3'b000});
    q_entry.len   = len;
    q_entry.grp7  = grp7;
    q_entry.err   = err;
  end

endmodule

`default_nettype wire

// File: src/vlqe_queue.sv
// vlqe_queue: short register queue of classified entries between front and back
// depends on vlqe_pkg for the entry type
`default_nettype none

module vlqe_queue #(
  parameter int unsigned Depth = vlqe_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr,
  input  wire vlqe_pkg::entry_t  wr_entry,
  input  wire logic              rd,
  output vlqe_pkg::entry_t       head,
  output logic                   full,
  output logic                   q_empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  vlqe_pkg::entry_t slots [Depth];
  logic [PtrW-1:0]  wptr;
  logic [PtrW-1:0]  rptr;
  logic [CntW-1:0]  count;

  assign full    = count == CntW'(Depth);
  assign q_empty = count == '0;
  assign head    = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : wptr + 1'b1;
      if (rd) rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : rptr + 1'b1;
      if (wr && !rd)      count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots[wptr] <= wr_entry;
  end

endmodule

`default_nettype wire

// File: src/vlqe_back.sv
// vlqe_back: emits one byte per cycle from queued entries into an output register while pop keeps it free
// depends on vlqe_pkg for the entry type
`default_nettype none

module vlqe_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire vlqe_pkg::entry_t  q_head,
  output logic                   q_pop,
  input  wire logic              pop,
  output logic                   empty,
  output logic [7:0]             out_byte,
  output logic                   last,
  output logic                   status
);

  logic                         busy;
  logic                         out_valid;
  logic [vlqe_pkg::BYTES_W-1:0] shreg;
  logic [3:0]                   remaining;
  logic                         cur_grp7;

  logic [vlqe_pkg::BYTES_W-1:0] src_bytes;
  logic [3:0]                   src_rem;
  logic                         src_grp7;
  logic                         src_err;
  logic                         fin;
  logic                         step;
  logic [7:0]                   b;

  assign empty = !out_valid;

  always_comb begin
    src_bytes = busy ? shreg     : q_head.bytes;
    src_rem   = busy ? remaining : q_head.len;
    src_grp7  = busy ? cur_grp7  : q_head.grp7;
    src_err   = !busy && q_head.err;
    fin       = src_err || (src_rem == 4'd1);
    b         = src_bytes[vlqe_pkg::BYTES_W-1 -: 8];
    // output slot frees when empty or being taken this cycle
    step      = (!out_valid || pop) && (busy || !q_empty);
    q_pop     = step && !busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
        busy      <= !fin;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte  <= src_err ? 8'h00 : ((src_grp7 && !fin) ? (b | 8'h80) : b);
      last      <= fin;
      status    <= src_err;
      shreg     <= src_bytes << 8;
      remaining <= src_rem - 4'd1;
      cur_grp7  <= src_grp7;
    end
  end

endmodule

`default_nettype wire

// File: src/vlqe_checker.sv
// vlqe_checker: port-level assertions for varint_integer_encoder
// attached to the top level by the bind statement at the end of this file
`default_nettype none

module vlqe_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte,
  input wire logic       last,
  input wire logic       status
);

  a_reset_idle: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queue not idle after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(last) && $stable(status))
    else $error("waiting result changed");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    !empty && status |-> last)
    else $error("error result not marked last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && status |-> out_byte == 8'h00)
    else $error("error result carries a nonzero byte");

endmodule

bind varint_integer_encoder vlqe_checker u_vlqe_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_byte (out_byte),
  .last     (last),
  .status   (status)
);

`default_nettype wire
